// ===== sv/deadline_timer_table_assert.svh =====
// Assertion macros for the deadline timer table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef DEADLINE_TIMER_TABLE_ASSERT_SVH
`define DEADLINE_TIMER_TABLE_ASSERT_SVH
// Implication or plain property, checked out of reset
`define DTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next
`define DTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/dtt_pkg.sv =====
// Shared constants and types for the deadline timer table.
// No dependencies.
package dtt_pkg;

  localparam int unsigned TimerSlotsDefault = 16;
  localparam logic [31:0] WindowResetMs     = 32'(60 * 60 * 1000);
  localparam logic [63:0] NoTimer           = '1;
  localparam int unsigned MaxOut            = 16;

  // Operation codes
  localparam logic [2:0] FnAdd     = 3'd0;
  localparam logic [2:0] FnCancel  = 3'd1;
  localparam logic [2:0] FnRefresh = 3'd2;
  localparam logic [2:0] FnReset   = 3'd3;
  localparam logic [2:0] FnQuery   = 3'd4;
  localparam logic [2:0] FnCollect = 3'd5;

  // Result status codes
  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StNotAct  = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StNone    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_RDW, S_RST2, S_SCAN, S_FIN, S_PERW, S_OUT
  } dtt_state_t;

endpackage

// ===== sv/dtt_if.sv =====
// Request and result channel interfaces of the deadline timer table.
// No dependencies.
interface dtt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] now_ms;
  logic [3:0]  slot;
  logic [31:0] period_ms;
  logic        recurring;
  logic        restart_now;
  modport source (output valid, func, now_ms, slot, period_ms, recurring, restart_now,
                  input ready);
  modport sink   (input valid, func, now_ms, slot, period_ms, recurring, restart_now,
                  output ready);
endinterface

interface dtt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot_id;
  logic [63:0] wait_ms;
  logic        front_new;
  logic        last;
  modport source (output valid, status, slot_id, wait_ms, front_new, last, input ready);
  modport sink   (input valid, status, slot_id, wait_ms, front_new, last, output ready);
endinterface

// ===== sv/dtt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/deadline_timer_table.sv =====
// Deadline timer table top level: sequencer, slot flags and deadline scan.
// Depends on dtt_pkg, dtt_if (dtt_req_if, dtt_rsp_if), dtt_ram and deadline_timer_table_assert.svh.
//
//   channel   direction  handshake         carries
//   in_ch     in         valid / ready     one request: func, now, slot, period, flags
//   out_ch    out        valid / ready     one result: status, slot_id, wait, front_new, last
//   cfg_*     in         cfg_we            rollback window (ms)
//
// Add, query and collect, and a reset that changes the timer, scan all TIMER_SLOTS slots;
// the scan reads one deadline per slot. Collect rescans before each due slot it emits
// and rewrites the deadline of a recurring slot.
// Reset: synchronous; flags clear at once, period and deadline memories are not cleared.
// Stalls: a finished result waits in the output register; a new request is taken
// once the sequencer is back in idle.
module deadline_timer_table import dtt_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = TimerSlotsDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  dtt_req_if.sink       in_ch,
  dtt_rsp_if.source     out_ch,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(TIMER_SLOTS - 1);

  dtt_state_t state_r, state_nxt;

  // Request and control registers
  logic [31:0]          window_r;
  logic [2:0]           func_r;
  logic [63:0]          now_r;
  logic [3:0]           slot_r;
  logic [31:0]          period_r;
  logic                 rec_in_r;
  logic                 fnow_r;
  logic [63:0]          back_r;
  logic                 behind_r;
  logic                 roll_r;
  logic [TIMER_SLOTS-1:0] active_r, recur_r, due_r;
  logic                 front_r;
  logic [63:0]          last_seen_r;
  logic [IW-1:0]        tgt_r;
  logic                 phase_r;
  logic [3:0]           k_r;
  logic [63:0]          start_r;

  // Scan registers
  logic [IW-1:0]        cnt_r, pidx_r, best_idx_r;
  logic                 issue_r, pv_r, plast_r, found_r;
  logic [63:0]          best_dl_r;

  // Pending result and output register
  logic [1:0]           rs_status_r;
  logic [3:0]           rs_slot_r;
  logic [63:0]          rs_wait_r;
  logic                 rs_front_r, rs_last_r, more_r;
  logic                 out_v_r;
  logic [1:0]           out_status_r;
  logic [3:0]           out_slot_r;
  logic [63:0]          out_wait_r;
  logic                 out_front_r, out_last_r;

  // Memory ports
  logic                 per_we, dl_we;
  logic [IW-1:0]        wr_addr, rd_addr;
  logic [31:0]          per_wdata, per_q;
  logic [63:0]          dl_wdata, dl_q;

  dtt_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_period (
    .clk(clk), .we(per_we), .waddr(wr_addr), .wdata(per_wdata),
    .raddr(rd_addr), .rdata(per_q)
  );

  dtt_ram #(.WIDTH(64), .DEPTH(TIMER_SLOTS)) u_deadline (
    .clk(clk), .we(dl_we), .waddr(wr_addr), .wdata(dl_wdata),
    .raddr(rd_addr), .rdata(dl_q)
  );

  // Slot decode and lowest free slot
  logic [IW-1:0] s_idx, free_idx;
  logic          s_ok, s_act, free_ok;

  assign s_idx = IW'(slot_r);
  assign s_ok  = 32'(slot_r) < TIMER_SLOTS;
  assign s_act = s_ok && active_r[s_idx];

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Scan compare on the deadline returned for pidx_r
  logic cand, better, scan_done;
  assign cand      = phase_r ? due_r[pidx_r] : active_r[pidx_r];
  assign better    = pv_r && cand && (!found_r || dl_q < best_dl_r);
  assign scan_done = pv_r && plast_r;

  // Due set without the slot just chosen
  logic [TIMER_SLOTS-1:0] due_rem;
  always_comb begin
    due_rem = due_r;
    due_rem[best_idx_r] = 1'b0;
  end

  logic out_load, in_acc, emit_last;
  assign out_load  = (state_r == S_OUT) && (!out_v_r || out_ch.ready);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign emit_last = (due_rem == '0) || (k_r == 4'(MaxOut - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DISP;
      S_DISP: begin
        unique case (func_r)
          FnAdd:     state_nxt = free_ok ? S_SCAN : S_OUT;
          FnRefresh: state_nxt = s_act ? S_RDW : S_OUT;
          FnReset:   state_nxt = s_ok ? S_RDW : S_OUT;
          FnQuery,
          FnCollect: state_nxt = S_SCAN;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_RDW: begin
        if (func_r == FnReset && (fnow_r || period_r != per_q) && s_act) begin
          state_nxt = S_RST2;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RST2: state_nxt = S_SCAN;
      S_SCAN: if (scan_done) state_nxt = S_FIN;
      S_FIN: begin
        if (func_r == FnCollect && !phase_r && found_r &&
            (roll_r || best_dl_r <= now_r)) begin
          state_nxt = S_SCAN;
        end else if (func_r == FnCollect && phase_r && recur_r[best_idx_r]) begin
          state_nxt = S_PERW;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PERW: state_nxt = S_OUT;
      S_OUT: if (out_load) state_nxt = more_r ? S_SCAN : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    per_we    = 1'b0;
    dl_we     = 1'b0;
    wr_addr   = s_idx;
    per_wdata = period_r;
    dl_wdata  = now_r + 64'(period_r);
    rd_addr   = s_idx;
    unique case (state_r)
      S_DISP: begin
        if (func_r == FnAdd && free_ok) begin
          per_we  = 1'b1;
          dl_we   = 1'b1;
          wr_addr = free_idx;
        end
      end
      S_RDW: begin
        if (func_r == FnRefresh) begin
          dl_we    = 1'b1;
          dl_wdata = now_r + 64'(per_q);
        end
      end
      S_RST2: begin
        per_we   = 1'b1;
        dl_we    = 1'b1;
        dl_wdata = start_r + 64'(period_r);
      end
      S_SCAN: rd_addr = cnt_r;
      S_FIN:  rd_addr = best_idx_r;
      S_PERW: begin
        dl_we    = 1'b1;
        wr_addr  = best_idx_r;
        dl_wdata = now_r + 64'(per_q);
      end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= WindowResetMs;
      active_r    <= '0;
      recur_r     <= '0;
      due_r       <= '0;
      front_r     <= 1'b0;
      last_seen_r <= '0;
      issue_r     <= 1'b0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      phase_r     <= 1'b0;
      more_r      <= 1'b0;
      k_r         <= '0;
      out_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end

      // Start a scan on entry to the scan state
      if (state_r != S_SCAN && state_nxt == S_SCAN) begin
        cnt_r   <= '0;
        issue_r <= 1'b1;
        pv_r    <= 1'b0;
        found_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r   <= in_ch.func;
            now_r    <= in_ch.now_ms;
            slot_r   <= in_ch.slot;
            period_r <= in_ch.period_ms;
            rec_in_r <= in_ch.recurring;
            fnow_r   <= in_ch.restart_now;
            back_r   <= last_seen_r - in_ch.now_ms;
            behind_r <= in_ch.now_ms < last_seen_r;
          end
        end
        S_DISP: begin
          rs_status_r <= StDone;
          rs_slot_r   <= '0;
          rs_wait_r   <= '0;
          rs_front_r  <= 1'b0;
          rs_last_r   <= 1'b1;
          more_r      <= 1'b0;
          phase_r     <= 1'b0;
          tgt_r       <= s_idx;
          roll_r      <= behind_r && (back_r > 64'(window_r));
          unique case (func_r)
            FnAdd: begin
              if (free_ok) begin
                active_r[free_idx] <= 1'b1;
                recur_r[free_idx]  <= rec_in_r;
                tgt_r              <= free_idx;
              end else begin
                rs_status_r <= StFull;
              end
            end
            FnCancel: begin
              if (s_act) begin
                active_r[s_idx] <= 1'b0;
              end else begin
                rs_status_r <= StNotAct;
              end
            end
            FnRefresh, FnReset: begin
              if (!s_ok || (func_r == FnRefresh && !s_act)) begin
                rs_status_r <= StNotAct;
              end
            end
            FnQuery:   front_r <= 1'b0;
            FnCollect: ;
            default:   rs_status_r <= StNone;
          endcase
        end
        S_RDW: begin
          if (func_r == FnReset && (fnow_r || period_r != per_q)) begin
            if (!s_act) begin
              rs_status_r <= StNotAct;
            end
            start_r <= fnow_r ? now_r : dl_q - 64'(per_q);
          end
        end
        S_SCAN: begin
          // Issue one read per slot, evaluate one slot per cycle
          if (issue_r) begin
            cnt_r   <= cnt_r + 1'b1;
            issue_r <= cnt_r != LastIdx;
          end
          pv_r    <= issue_r;
          pidx_r  <= cnt_r;
          plast_r <= cnt_r == LastIdx;
          if (pv_r) begin
            found_r <= found_r || cand;
            if (better) begin
              best_idx_r <= pidx_r;
              best_dl_r  <= dl_q;
            end
            if (!phase_r) begin
              due_r[pidx_r] <= active_r[pidx_r] && (roll_r || dl_q <= now_r);
            end
          end
        end
        S_FIN: begin
          unique case (func_r)
            FnAdd, FnReset: begin
              if (found_r && best_idx_r == tgt_r && !front_r) begin
                front_r    <= 1'b1;
                rs_front_r <= 1'b1;
              end
              if (func_r == FnAdd) begin
                rs_slot_r <= 4'(tgt_r);
              end
            end
            FnQuery: begin
              if (!found_r) begin
                rs_status_r <= StNone;
                rs_wait_r   <= NoTimer;
              end else if (now_r < best_dl_r) begin
                rs_wait_r   <= best_dl_r - now_r;
              end
            end
            FnCollect: begin
              if (!phase_r) begin
                if (!found_r) begin
                  rs_status_r <= StNone;
                end else begin
                  last_seen_r <= now_r;
                  if (!roll_r && best_dl_r > now_r) begin
                    rs_status_r <= StNone;
                  end else begin
                    phase_r <= 1'b1;
                    k_r     <= '0;
                  end
                end
              end else begin
                // Emit the earliest due slot; drop or reschedule it
                due_r[best_idx_r] <= 1'b0;
                if (!recur_r[best_idx_r]) begin
                  active_r[best_idx_r] <= 1'b0;
                end
                rs_status_r <= StDone;
                rs_slot_r   <= 4'(best_idx_r);
                rs_last_r   <= emit_last;
                more_r      <= !emit_last;
              end
            end
            default: ;
          endcase
        end
        S_OUT: begin
          if (out_load && more_r) begin
            k_r <= k_r + 1'b1;
          end
        end
        default: ;
      endcase

      // Output register
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= rs_status_r;
      out_slot_r   <= rs_slot_r;
      out_wait_r   <= rs_wait_r;
      out_front_r  <= rs_front_r;
      out_last_r   <= rs_last_r;
    end
  end

  assign in_ch.ready      = state_r == S_IDLE;
  assign out_ch.valid     = out_v_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.slot_id   = out_slot_r;
  assign out_ch.wait_ms   = out_wait_r;
  assign out_ch.front_new = out_front_r;
  assign out_ch.last      = out_last_r;

  // Finish cycles of a front check and of a collect emission
  logic front_fin, emit_fin;
  assign front_fin = state_r == S_FIN && (func_r == FnAdd || func_r == FnReset);
  assign emit_fin  = state_r == S_FIN && func_r == FnCollect && phase_r;

`include "deadline_timer_table_assert.svh"

  `DTT_ASSERT(a_front_src, $rose(front_r) |-> $past(front_fin), "front flag set outside add or reset")
  `DTT_ASSERT(a_emit_found, emit_fin |-> found_r, "collect emission scan found no due slot")
  `DTT_ASSERT(a_accept_clean, in_acc |-> !more_r, "request accepted while emissions remain")
  `DTT_ASSERT_NEXT(a_scan_leave, state_r == S_SCAN && scan_done, state_r == S_FIN, "scan stuck")

endmodule

// ===== dv/deadline_timer_table_tb.sv =====
// Self-checking testbench for deadline_timer_table: directed table, then random requests.
// Depends on dtt_pkg, dtt_if (dtt_req_if, dtt_rsp_if) and the deadline_timer_table RTL.
`timescale 1ns / 100ps

module deadline_timer_table_tb;
  import dtt_pkg::*;

  localparam int Slots = 16;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  slot_id;
    logic [63:0] wait_ms;
    logic        front_new;
    logic        last;
  } result_t;

  typedef struct {
    logic [2:0]  func;
    logic [63:0] now_ms;
    logic [3:0]  slot;
    logic [31:0] period_ms;
    logic        recurring;
    logic        restart_now;
    bit          typed;
    result_t     want;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [31:0] cfg_wdata;
  int errors = 0;

  dtt_req_if in_ch();
  dtt_rsp_if out_ch();

  deadline_timer_table DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the timer table
  bit          t_active [Slots];
  bit          t_recur [Slots];
  bit          t_written [Slots];
  logic [31:0] t_period [Slots];
  logic [63:0] t_deadline [Slots];
  bit          t_front;
  logic [63:0] t_last_seen;
  logic [31:0] t_window;

  result_t expected_results[$];
  request_t script[$];

  function automatic bit runs_ahead(int a, int b);
    if (t_deadline[a] != t_deadline[b]) return t_deadline[a] < t_deadline[b];
    return a < b;
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < Slots; i++)
      if (t_active[i] && (best < 0 || runs_ahead(i, best))) best = i;
    return best;
  endfunction

  function automatic logic front_check(int s);
    if (earliest_slot() == s && !t_front) begin
      t_front = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t mk(logic [1:0] st, logic [3:0] id, logic [63:0] w, logic f);
    result_t r;
    r.status = st; r.slot_id = id; r.wait_ms = w; r.front_new = f; r.last = 1'b0;
    return r;
  endfunction

  // Advance the shadow table by one request and return its results
  task automatic predict_timers(input request_t q, output result_t res[$]);
    int s, e, b, k, fi;
    bit roll;
    logic [15:0] due;
    logic [63:0] start;
    s = q.slot;
    res = {};
    case (q.func)
      FnAdd: begin
        fi = -1;
        for (int i = 0; i < Slots; i++)
          if (!t_active[i] && fi < 0) fi = i;
        if (fi < 0) res = {res, mk(StFull, 0, 0, 0)};
        else begin
          t_active[fi] = 1; t_recur[fi] = q.recurring; t_written[fi] = 1;
          t_period[fi] = q.period_ms;
          t_deadline[fi] = q.now_ms + 64'(q.period_ms);
          res = {res, mk(StDone, 4'(fi), 0, front_check(fi))};
        end
      end
      FnCancel: begin
        if (t_active[s]) begin
          t_active[s] = 0;
          res = {res, mk(StDone, 0, 0, 0)};
        end else res = {res, mk(StNotAct, 0, 0, 0)};
      end
      FnRefresh: begin
        if (t_active[s]) begin
          t_deadline[s] = q.now_ms + 64'(t_period[s]);
          res = {res, mk(StDone, 0, 0, 0)};
        end else res = {res, mk(StNotAct, 0, 0, 0)};
      end
      FnReset: begin
        if (!q.restart_now && q.period_ms == t_period[s]) res = {res, mk(StDone, 0, 0, 0)};
        else if (!t_active[s]) res = {res, mk(StNotAct, 0, 0, 0)};
        else begin
          start = q.restart_now ? q.now_ms : t_deadline[s] - 64'(t_period[s]);
          t_period[s] = q.period_ms;
          t_deadline[s] = start + 64'(q.period_ms);
          res = {res, mk(StDone, 0, 0, front_check(s))};
        end
      end
      FnQuery: begin
        e = earliest_slot();
        t_front = 0;
        if (e < 0) res = {res, mk(StNone, 0, NoTimer, 0)};
        else if (q.now_ms >= t_deadline[e]) res = {res, mk(StDone, 0, 0, 0)};
        else res = {res, mk(StDone, 0, t_deadline[e] - q.now_ms, 0)};
      end
      FnCollect: begin
        e = earliest_slot();
        if (e < 0) res = {res, mk(StNone, 0, 0, 0)};
        else begin
          roll = q.now_ms < t_last_seen && (t_last_seen - q.now_ms) > 64'(t_window);
          t_last_seen = q.now_ms;
          if (!roll && t_deadline[e] > q.now_ms) res = {res, mk(StNone, 0, 0, 0)};
          else begin
            due = '0;
            for (int i = 0; i < Slots; i++)
              if (t_active[i] && (roll || t_deadline[i] <= q.now_ms)) due[i] = 1'b1;
            // Emit in deadline order; the due set was fixed above
            k = 0;
            while (due != 0 && k < MaxOut) begin
              b = -1;
              for (int i = 0; i < Slots; i++)
                if (due[i] && (b < 0 || runs_ahead(i, b))) b = i;
              due[b] = 1'b0;
              if (t_recur[b]) t_deadline[b] = q.now_ms + 64'(t_period[b]);
              else t_active[b] = 0;
              res = {res, mk(StDone, 4'(b), 0, 0)};
              k++;
            end
          end
        end
      end
      default: res = {res, mk(StNone, 0, 0, 0)};
    endcase
    res[res.size() - 1].last = 1'b1;
  endtask

  // Drive one request and queue its expected results on acceptance
  task automatic send_request(input request_t q);
    result_t res[$];
    in_ch.valid <= 1'b1;
    in_ch.func <= q.func;
    in_ch.now_ms <= q.now_ms;
    in_ch.slot <= q.slot;
    in_ch.period_ms <= q.period_ms;
    in_ch.recurring <= q.recurring;
    in_ch.restart_now <= q.restart_now;
    do @(posedge clk); while (!in_ch.ready);
    predict_timers(q, res);
    if (q.typed) begin
      q.want.last = 1'b1;
      res = '{q.want};
    end
    foreach (res[i]) expected_results = {expected_results, res[i]};
  endtask

  task automatic drain_and_write(input logic [31:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    t_window = v;
  endtask

  function automatic request_t row(logic [2:0] f, logic [63:0] now, logic [3:0] s,
                                   logic [31:0] p, logic rc, logic fn);
    request_t q;
    q.func = f; q.now_ms = now; q.slot = s; q.period_ms = p;
    q.recurring = rc; q.restart_now = fn; q.typed = 0;
    q.want = mk(0, 0, 0, 0);
    return q;
  endfunction

  function automatic request_t fixed(request_t q, result_t r);
    q.typed = 1;
    q.want = r;
    return q;
  endfunction

  // Receiver stall pattern: alternating modes of always-ready, every third, random
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case ((stall_cnt / 200) % 3)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= (stall_cnt % 3) == 0;
      default: out_ch.ready <= $urandom_range(0, 3) != 0;
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d slot_id %0d", out_ch.status, out_ch.slot_id);
        errors++;
      end else begin
        w = expected_results.pop_front();
        if (out_ch.status !== w.status) begin
          $error("status: expected %0d, actual %0d", w.status, out_ch.status); errors++;
        end
        if (out_ch.slot_id !== w.slot_id) begin
          $error("slot_id: expected %0d, actual %0d", w.slot_id, out_ch.slot_id); errors++;
        end
        if (out_ch.wait_ms !== w.wait_ms) begin
          $error("wait_ms: expected %0h, actual %0h", w.wait_ms, out_ch.wait_ms); errors++;
        end
        if (out_ch.front_new !== w.front_new) begin
          $error("front_new: expected %0d, actual %0d", w.front_new, out_ch.front_new);
          errors++;
        end
        if (out_ch.last !== w.last) begin
          $error("last: expected %0d, actual %0d", w.last, out_ch.last); errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    request_t q;
    logic [63:0] tnow;
    logic [31:0] windows [4];
    int burst, pick, s, sent, gap;
    in_ch.valid <= 1'b0;
    in_ch.func <= FnQuery;
    in_ch.now_ms <= '0;
    in_ch.slot <= '0;
    in_ch.period_ms <= '0;
    in_ch.recurring <= 1'b0;
    in_ch.restart_now <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    for (int i = 0; i < Slots; i++) begin
      t_active[i] = 0; t_recur[i] = 0; t_written[i] = 0;
      t_period[i] = '0; t_deadline[i] = '0;
    end
    t_front = 0; t_last_seen = '0; t_window = WindowResetMs;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, inactive slots, unknown codes, extremes, full table, wrap
    script = {script, fixed(row(FnQuery, 0, 0, 0, 0, 0), mk(StNone, 0, NoTimer, 0))};
    script = {script, fixed(row(FnCollect, 0, 0, 0, 0, 0), mk(StNone, 0, 0, 0))};
    script = {script, fixed(row(FnCancel, 0, 0, 0, 0, 0), mk(StNotAct, 0, 0, 0))};
    script = {script, fixed(row(FnRefresh, 0, 15, 0, 0, 0), mk(StNotAct, 0, 0, 0))};
    script = {script, fixed(row(3'd6, '1, 15, '1, 1, 1), mk(StNone, 0, 0, 0))};
    script = {script, fixed(row(3'd7, 0, 0, 0, 0, 0), mk(StNone, 0, 0, 0))};
    script = {script, fixed(row(FnAdd, 100, 0, 0, 0, 0), mk(StDone, 0, 0, 1))};
    script = {script, row(FnAdd, 100, 0, '1, 1, 0)};
    script = {script, row(FnReset, 100, 1, 50, 0, 1)};
    script = {script, row(FnReset, 100, 1, 50, 0, 0)};
    script = {script, row(FnReset, 100, 1, 70, 0, 0)};
    script = {script, row(FnRefresh, 120, 1, 0, 0, 0)};
    script = {script, row(FnQuery, 110, 0, 0, 0, 0)};
    script = {script, row(FnQuery, 400, 0, 0, 0, 0)};
    script = {script, row(FnCollect, 200, 0, 0, 0, 0)};
    for (int i = 0; i < 15; i++)
      script = {script, row(FnAdd, 64'hFFFF_FFFF_FFFF_FFF0 + i, 0, 20, 1'(i % 2), 0)};
    script = {script, fixed(row(FnAdd, 0, 0, 5, 0, 0), mk(StFull, 0, 0, 0))};
    script = {script, row(FnCollect, 10, 0, 0, 0, 0)};
    script = {script, row(FnCancel, 10, 3, 0, 0, 0)};
    foreach (script[i]) send_request(script[i]);

    // Random phases, each under its own rollback window
    windows[0] = 32'd0;
    windows[1] = '1;
    windows[2] = $urandom_range(1, 500);
    windows[3] = WindowResetMs;
    tnow = 64'd1000;
    sent = 0;
    burst = 0;
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_write(windows[ph]);
      for (int n = 0; n < 72; n++) begin
        // Gap between bursts
        if (burst == 0) begin
          gap = $urandom_range(0, 20);
          if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst = $urandom_range(1, 15);
        end
        burst--;
        if (sent == 150) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (expected_results.size() != 0) @(posedge clk);
        end
        // Time mostly advances slowly; now and then jump anywhere or back
        pick = $urandom_range(0, 39);
        if (pick == 0) tnow = {$urandom, $urandom};
        else if (pick == 1) tnow = tnow - 64'($urandom_range(0, 1000));
        else if (pick == 2) tnow = tnow - 64'($urandom);
        else tnow = tnow + 64'($urandom_range(0, 60));
        q = row(FnQuery, tnow, 4'($urandom_range(0, 15)), 32'($urandom_range(0, 300)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 15) == 0) q.period_ms = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 27) q.func = FnAdd;
        else if (pick < 36) q.func = FnCancel;
        else if (pick < 45) q.func = FnRefresh;
        else if (pick < 60) q.func = FnReset;
        else if (pick < 73) q.func = FnQuery;
        else if (pick < 97) q.func = FnCollect;
        else q.func = 3'($urandom_range(6, 7));
        // Reset only on slots whose period has been written
        if (q.func == FnReset) begin
          s = q.slot;
          if (!t_written[s]) begin
            s = -1;
            for (int i = 0; i < Slots; i++) if (t_written[i] && s < 0) s = i;
          end
          if (s < 0) q.func = FnAdd;
          else begin
            q.slot = 4'(s);
            if ($urandom_range(0, 3) == 0) q.period_ms = t_period[s];
          end
        end
        send_request(q);
        sent++;
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== deadline_timer_table.f =====
+incdir+sv
sv/dtt_pkg.sv
sv/dtt_if.sv
sv/dtt_ram.sv
sv/deadline_timer_table.sv
dv/deadline_timer_table_tb.sv
